[design/mcda_pkg.sv]
// Shared constants and types for the multi-operand decimal column adder.
// No dependencies; every other design file refers to it by scoped names.
package mcda_pkg;

  localparam int DIGIT_COLUMNS_DEF = 10;
  localparam int MAX_OPERANDS_DEF  = 8;

  localparam int RADIX         = 10;
  localparam int OPERAND_W     = 34;
  localparam int DIGIT_W       = 4;
  localparam int SUM_W         = 40;
  localparam int CARRY_OUT_W   = 4;
  localparam int COL_W         = 7;

  // 34-bit binary needs 11 decimal digits
  localparam int BCD_DIGITS    = 11;
  localparam int BCD_W         = BCD_DIGITS * DIGIT_W;

  // binary-to-BCD conversion: two bits shifted in per cycle
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS    = (OPERAND_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SHIFT_W       = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS + 1);

  typedef struct packed {
    logic start;
  } conv_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_sts_t;

endpackage

[design/mcda_if.sv]
// Word channels of the decimal column adder: operand input and result output.
// Depends on mcda_pkg for the payload widths.
interface mcda_in_if;
  logic                            valid;
  logic                            ready;
  logic [mcda_pkg::OPERAND_W-1:0]  operand_value;
  logic                            last;

  modport source (output valid, output operand_value, output last, input ready);
  modport sink   (input valid, input operand_value, input last, output ready);
endinterface

interface mcda_out_if;
  logic                              valid;
  logic                              ready;
  logic [mcda_pkg::SUM_W-1:0]        sum_bcd;
  logic [mcda_pkg::SUM_W-1:0]        carry_bcd;
  logic [mcda_pkg::CARRY_OUT_W-1:0]  carry_out;
  logic                              too_many;

  modport source (output valid, output sum_bcd, output carry_bcd, output carry_out,
                  output too_many, input ready);
  modport sink   (input valid, input sum_bcd, input carry_bcd, input carry_out,
                  input too_many, output ready);
endinterface

[design/mcda_bin2bcd.sv]
// Serial binary-to-BCD converter (shift and add-3), two bits per cycle.
// Depends on mcda_pkg for widths and the control/status structs.
module mcda_bin2bcd (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mcda_pkg::conv_ctl_t             ctl,
  input  logic [mcda_pkg::OPERAND_W-1:0]  value,
  output mcda_pkg::conv_sts_t             sts,
  output logic [mcda_pkg::BCD_W-1:0]      digits
);

  logic [mcda_pkg::SHIFT_W-1:0]    bin_r, bin_nxt;
  logic [mcda_pkg::BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [mcda_pkg::STEP_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            done_r, done_nxt;

  function automatic logic [mcda_pkg::DIGIT_W-1:0] bcd_adjust(
      input logic [mcda_pkg::DIGIT_W-1:0] d);
    return (d >= mcda_pkg::DIGIT_W'(5)) ? d + mcda_pkg::DIGIT_W'(3) : d;
  endfunction

  always_comb begin
    logic [mcda_pkg::SHIFT_W-1:0] bin_t;
    logic [mcda_pkg::BCD_W-1:0]   bcd_t;
    bin_t = bin_r;
    bcd_t = bcd_r;
    for (int s = 0; s < mcda_pkg::BITS_PER_STEP; s++) begin
      for (int k = 0; k < mcda_pkg::BCD_DIGITS; k++) begin
        bcd_t[k*mcda_pkg::DIGIT_W +: mcda_pkg::DIGIT_W] =
          bcd_adjust(bcd_t[k*mcda_pkg::DIGIT_W +: mcda_pkg::DIGIT_W]);
      end
      {bcd_t, bin_t} = {bcd_t, bin_t} << 1;
    end

    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      bin_nxt = mcda_pkg::SHIFT_W'(value);
      bcd_nxt = '0;
      cnt_nxt = mcda_pkg::STEP_CNT_W'(mcda_pkg::CONV_STEPS);
    end else if (cnt_r != '0) begin
      bin_nxt  = bin_t;
      bcd_nxt  = bcd_t;
      cnt_nxt  = cnt_r - mcda_pkg::STEP_CNT_W'(1);
      done_nxt = (cnt_r == mcda_pkg::STEP_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  assign digits   = bcd_r;

endmodule

[design/multi_operand_decimal_column_adder.sv]
// Multi-operand decimal column adder, top level.
// Per operand word: accept, serial conversion in mcda_bin2bcd, then the add into the columns.
// Last word then adds a carry walk over the DIGIT_COLUMNS columns and a load of the result
// register, which waits while the output is stalled; conversion and walk are one word at a time.
// Synchronous active-low reset clears columns, operand count, overflow flag and output valid.
module multi_operand_decimal_column_adder #(
  parameter int DIGIT_COLUMNS = mcda_pkg::DIGIT_COLUMNS_DEF,
  parameter int MAX_OPERANDS  = mcda_pkg::MAX_OPERANDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mcda_in_if.sink     in_ch,
  mcda_out_if.source  out_ch
);

  localparam int CNT_W   = $clog2(MAX_OPERANDS + 1);
  localparam int PACK_W  = DIGIT_COLUMNS * mcda_pkg::DIGIT_W;
  localparam int IDX_W   = (DIGIT_COLUMNS > 1) ? $clog2(DIGIT_COLUMNS) : 1;
  localparam int EXT_W   = ((DIGIT_COLUMNS > mcda_pkg::BCD_DIGITS) ? DIGIT_COLUMNS
                                                                   : mcda_pkg::BCD_DIGITS)
                           * mcda_pkg::DIGIT_W;
  // x / 10 == (x * 205) >> 11 for every 7-bit x
  localparam int RECIP_10    = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = mcda_pkg::COL_W + 8;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_WALK, S_DONE} state_t;

  state_t                           state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             last_r, last_nxt;
  logic [mcda_pkg::COL_W-1:0]       col_r [DIGIT_COLUMNS];
  logic [mcda_pkg::COL_W-1:0]       col_nxt [DIGIT_COLUMNS];
  logic [mcda_pkg::DIGIT_W-1:0]     carry_r, carry_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [PACK_W-1:0]                sum_sr_r, sum_sr_nxt;
  logic [PACK_W-1:0]                carry_sr_r, carry_sr_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             load_out;

  logic [mcda_pkg::SUM_W-1:0]       sum_bcd_r;
  logic [mcda_pkg::SUM_W-1:0]       carry_bcd_r;
  logic [mcda_pkg::CARRY_OUT_W-1:0] carry_out_r;
  logic                             too_many_r;

  mcda_pkg::conv_ctl_t              conv_ctl;
  mcda_pkg::conv_sts_t              conv_sts;
  logic [mcda_pkg::BCD_W-1:0]       conv_digits;
  logic [EXT_W-1:0]                 digits_ext;

  logic                             in_accept;
  logic                             room;
  logic                             out_free;
  logic [mcda_pkg::COL_W-1:0]       total;
  logic [mcda_pkg::DIGIT_W-1:0]     quot;
  logic [mcda_pkg::DIGIT_W-1:0]     rem;
  logic                             cols_zero;

  function automatic logic [mcda_pkg::DIGIT_W-1:0] div10(
      input logic [mcda_pkg::COL_W-1:0] t);
    logic [PROD_W-1:0] p;
    p = PROD_W'(t) * PROD_W'(RECIP_10);
    return mcda_pkg::DIGIT_W'(p >> RECIP_SHIFT);
  endfunction

  // Serial binary-to-decimal split of one operand
  mcda_bin2bcd u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (conv_ctl),
    .value  (in_ch.operand_value),
    .sts    (conv_sts),
    .digits (conv_digits)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign room        = (cnt_r < CNT_W'(MAX_OPERANDS));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign digits_ext  = EXT_W'(conv_digits);

  // Carry walk datapath: column 0 of the shifting column file plus incoming carry
  assign total = col_r[0] + mcda_pkg::COL_W'(carry_r);
  assign quot  = div10(total);
  assign rem   = mcda_pkg::DIGIT_W'(total - mcda_pkg::COL_W'(quot)
                                    * mcda_pkg::COL_W'(mcda_pkg::RADIX));

  always_comb begin
    logic [PACK_W+mcda_pkg::DIGIT_W-1:0] sum_tmp;
    logic [PACK_W+mcda_pkg::DIGIT_W-1:0] carry_tmp;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    last_nxt       = last_r;
    col_nxt        = col_r;
    carry_nxt      = carry_r;
    idx_nxt        = idx_r;
    sum_sr_nxt     = sum_sr_r;
    carry_sr_nxt   = carry_sr_r;
    conv_ctl.start = 1'b0;
    load_out       = 1'b0;
    sum_tmp        = {rem, sum_sr_r};
    carry_tmp      = {carry_r, carry_sr_r};

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (room) begin
            conv_ctl.start = 1'b1;
            last_nxt       = in_ch.last;
            state_nxt      = S_CONV;
          end else begin
            // group already full: drop the word, remember it
            ovf_nxt = 1'b1;
            if (in_ch.last) begin
              carry_nxt = '0;
              idx_nxt   = '0;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_CONV: begin
        if (conv_sts.done) begin
          for (int i = 0; i < DIGIT_COLUMNS; i++) begin
            col_nxt[i] = col_r[i]
                       + mcda_pkg::COL_W'(digits_ext[i*mcda_pkg::DIGIT_W +: mcda_pkg::DIGIT_W]);
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          if (last_r) begin
            carry_nxt = '0;
            idx_nxt   = '0;
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WALK: begin
        // one column per cycle; the column file shifts down and empties behind
        sum_sr_nxt   = sum_tmp[PACK_W+mcda_pkg::DIGIT_W-1:mcda_pkg::DIGIT_W];
        carry_sr_nxt = carry_tmp[PACK_W+mcda_pkg::DIGIT_W-1:mcda_pkg::DIGIT_W];
        carry_nxt    = quot;
        for (int i = 0; i < DIGIT_COLUMNS - 1; i++) begin
          col_nxt[i] = col_r[i+1];
        end
        col_nxt[DIGIT_COLUMNS-1] = '0;
        if (idx_r == IDX_W'(DIGIT_COLUMNS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ch.ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      carry_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGIT_COLUMNS; i++) begin
        col_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      carry_r     <= carry_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
    end
  end

  // Packed digit shift lines and the result word register
  always_ff @(posedge clk) begin
    sum_sr_r   <= sum_sr_nxt;
    carry_sr_r <= carry_sr_nxt;
    if (load_out) begin
      sum_bcd_r   <= mcda_pkg::SUM_W'(sum_sr_r);
      carry_bcd_r <= mcda_pkg::SUM_W'(carry_sr_r);
      carry_out_r <= carry_r;
      too_many_r  <= ovf_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.sum_bcd   = sum_bcd_r;
  assign out_ch.carry_bcd = carry_bcd_r;
  assign out_ch.carry_out = carry_out_r;
  assign out_ch.too_many  = too_many_r;

  always_comb begin
    cols_zero = 1'b1;
    for (int i = 0; i < DIGIT_COLUMNS; i++) begin
      if (col_r[i] != '0) begin
        cols_zero = 1'b0;
      end
    end
  end

  // Dropped word must raise the overflow flag
  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !room |=> ovf_r)
    else $error("overflow flag not set after dropped word");

  // Taken word starts the converter
  a_conv_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && room |=> (state_r == S_CONV) && conv_sts.busy)
    else $error("converter not started for accepted word");

  // Converter only runs while the FSM waits on it
  a_conv_owned: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CONV |-> !conv_sts.busy)
    else $error("converter busy outside conversion state");

  // Carry walk leaves the column file empty
  a_cols_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> cols_zero)
    else $error("column sums not cleared by carry walk");

  // Carry between columns is a single decimal digit
  a_carry_digit: assert property (@(posedge clk) disable iff (!rst_n)
    carry_r <= mcda_pkg::DIGIT_W'(mcda_pkg::RADIX - 1))
    else $error("column carry out of decimal range");

endmodule

[tb/sv/tb_multi_operand_decimal_column_adder.sv]
// Self-checking bench for the multi-operand decimal column adder: random and directed
// operand words, predicted BCD sums compared field by field. Needs mcda_pkg, mcda_if
// and the multi_operand_decimal_column_adder top level.
module tb_multi_operand_decimal_column_adder;

  localparam int DIGIT_COLUMNS = mcda_pkg::DIGIT_COLUMNS_DEF;
  localparam int MAX_OPERANDS  = mcda_pkg::MAX_OPERANDS_DEF;

  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT   = 3000;
  // settle time after the last drain, so that a late extra result would still be seen
  localparam int SETTLE_CYCLES = 2 * (20 + DIGIT_COLUMNS);
  localparam int WORDS_PER_PHASE = 210;

  localparam longint unsigned DECIMAL_TOP = 64'd9999999999;
  localparam longint unsigned OPERAND_MAX = (64'd1 << mcda_pkg::OPERAND_W) - 64'd1;

  typedef struct packed {
    logic [mcda_pkg::OPERAND_W-1:0] value;
    logic                           last;
  } operand_word_t;

  typedef struct packed {
    logic [mcda_pkg::SUM_W-1:0]       sum_bcd;
    logic [mcda_pkg::SUM_W-1:0]       carry_bcd;
    logic [mcda_pkg::CARRY_OUT_W-1:0] carry_out;
    logic                             too_many;
  } bcd_sum_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mcda_in_if  in_ch();
  mcda_out_if out_ch();

  // bench-side drive registers, known from time zero
  logic                           drv_valid = 1'b0;
  logic [mcda_pkg::OPERAND_W-1:0] drv_value = '0;
  logic                           drv_last  = 1'b0;
  logic                           rcv_ready = 1'b0;

  assign in_ch.valid         = drv_valid;
  assign in_ch.operand_value = drv_value;
  assign in_ch.last          = drv_last;
  assign out_ch.ready        = rcv_ready;

  multi_operand_decimal_column_adder #(
    .DIGIT_COLUMNS(DIGIT_COLUMNS),
    .MAX_OPERANDS (MAX_OPERANDS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block's column state, updated on every accepted word
  // ---------------------------------------------------------------------------
  logic [mcda_pkg::COL_W-1:0] col_total [DIGIT_COLUMNS];
  logic [3:0]                 held_count;
  logic                       dropped_seen;

  operand_word_t pending_words [$];
  bcd_sum_t      expected_sums [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int words_taken    = 0;
  int sums_checked   = 0;
  int dropped_groups = 0;

  task automatic clear_columns();
    for (int i = 0; i < DIGIT_COLUMNS; i++) col_total[i] = '0;
    held_count   = '0;
    dropped_seen = 1'b0;
  endtask

  // Fold one word into the columns; on a last word, walk the carries and
  // hand back the sum that the block must produce.
  task automatic absorb_word(input operand_word_t w, output bit has_sum, output bcd_sum_t s);
    longint unsigned rest;
    longint unsigned sum_packed;
    longint unsigned carry_packed;
    int unsigned     total;
    int unsigned     carry;
    has_sum      = 1'b0;
    s            = '0;
    sum_packed   = 0;
    carry_packed = 0;
    carry        = 0;
    if (held_count < MAX_OPERANDS) begin
      // only the low DIGIT_COLUMNS decimal digits land in a column
      rest = 64'(w.value);
      for (int i = 0; i < DIGIT_COLUMNS; i++) begin
        col_total[i] = col_total[i] + mcda_pkg::COL_W'(rest % mcda_pkg::RADIX);
        rest         = rest / mcda_pkg::RADIX;
      end
      held_count = held_count + 4'd1;
    end else begin
      // group already full: word dropped, flag set, count frozen
      dropped_seen = 1'b1;
    end
    if (w.last) begin
      // carry walk, column 0 upward; column 0 always enters with zero
      for (int i = 0; i < DIGIT_COLUMNS; i++) begin
        total         = int'(col_total[i]) + carry;
        carry_packed |= longint'(carry) << (4 * i);
        sum_packed   |= longint'(total % mcda_pkg::RADIX) << (4 * i);
        carry         = total / mcda_pkg::RADIX;
      end
      s.sum_bcd   = sum_packed[mcda_pkg::SUM_W-1:0];
      s.carry_bcd = carry_packed[mcda_pkg::SUM_W-1:0];
      s.carry_out = carry[mcda_pkg::CARRY_OUT_W-1:0];
      s.too_many  = dropped_seen;
      has_sum     = 1'b1;
      clear_columns();
    end
  endtask

  initial clear_columns();

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake, idle gaps drawn per cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    operand_word_t w;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_ch.ready) begin
      if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        w = pending_words.pop_front();
        drv_valid <= 1'b1;
        drv_value <= w.value;
        drv_last  <= w.last;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results first (a result never comes from a word taken at the
  // same edge), then predict from the accepted input word.
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input logic [mcda_pkg::SUM_W-1:0] exp_v,
                              input logic [mcda_pkg::SUM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    bcd_sum_t      want;
    bcd_sum_t      made;
    operand_word_t w;
    bit            has_sum;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual sum %h carry %h out %h flag %b",
                   $time, out_ch.sum_bcd, out_ch.carry_bcd, out_ch.carry_out, out_ch.too_many);
        end else begin
          want = expected_sums.pop_front();
          report_field("sum_bcd",   want.sum_bcd,          out_ch.sum_bcd);
          report_field("carry_bcd", want.carry_bcd,        out_ch.carry_bcd);
          report_field("carry_out", 40'(want.carry_out),   40'(out_ch.carry_out));
          report_field("too_many",  40'(want.too_many),    40'(out_ch.too_many));
          sums_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w.value = in_ch.operand_value;
        w.last  = in_ch.last;
        words_taken++;
        absorb_word(w, has_sum, made);
        if (has_sum) begin
          expected_sums.push_back(made);
          if (made.too_many) dropped_groups++;
        end
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    int quiet_cycles;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(input longint unsigned value, input bit last);
    operand_word_t w;
    w.value = value[mcda_pkg::OPERAND_W-1:0];
    w.last  = last;
    pending_words.push_back(w);
  endtask

  // Mostly in-range addends, some above ten digits, some built mostly from 9 digits
  // to stress long carry chains.
  function automatic longint unsigned pick_operand();
    longint unsigned raw;
    longint unsigned digits;
    int              pick;
    raw  = {$urandom_range(3, 0), $urandom()};
    pick = $urandom_range(99, 0);
    if (pick < 65) begin
      return raw % (DECIMAL_TOP + 1);
    end else if (pick < 80) begin
      return raw;
    end else begin
      digits = 0;
      for (int i = 0; i < 10; i++) begin
        digits = digits * 10 + (($urandom_range(3, 0) != 0) ? 9 : $urandom_range(8, 0));
      end
      return digits;
    end
  endfunction

  // Well-formed groups most of the time; some run past MAX_OPERANDS.
  task automatic queue_random_group(output int n);
    if ($urandom_range(99, 0) < 85) n = $urandom_range(MAX_OPERANDS, 1);
    else                            n = $urandom_range(MAX_OPERANDS + 4, MAX_OPERANDS + 1);
    for (int k = 0; k < n; k++) queue_word(pick_operand(), k == n - 1);
  endtask

  // Hold the sender until every word is taken and every expected sum has come.
  task automatic wait_for_drain();
    while (pending_words.size() != 0 || drv_valid || expected_sums.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int phase_words;
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero word alone
    queue_word(0, 1'b1);
    // full group of MAX_OPERANDS words of ten nines: every column at its largest, carries everywhere
    for (int k = 0; k < MAX_OPERANDS; k++) queue_word(DECIMAL_TOP, k == MAX_OPERANDS - 1);
    // largest 34-bit value: top decimal digit falls off
    queue_word(OPERAND_MAX, 1'b1);
    // ripple from column 0 through the top column into carry_out
    queue_word(1, 1'b0);
    queue_word(DECIMAL_TOP, 1'b1);
    // full group, then a dropped word and a dropped last: sum over held words, flag set
    for (int k = 0; k < MAX_OPERANDS; k++) queue_word(64'd1234567890, 1'b0);
    queue_word(64'd5555555555, 1'b0);
    queue_word(64'd7777777777, 1'b1);
    // alternating bit patterns over all 34 bits
    queue_word(64'h155555555, 1'b0);
    queue_word(64'h2AAAAAAAA, 1'b1);
    wait_for_drain();

    // random phases: free flow, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      phase_words = 0;
      while (phase_words < WORDS_PER_PHASE) begin
        queue_random_group(n);
        phase_words += n;
      end
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d operand words and %0d checked sums, %0d of them with dropped words,",
             words_taken, sums_checked, dropped_groups);
    $display("under free flow, sender gaps, receiver stalls and both together.");
    if (errors == 0 && expected_sums.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d sums never arrived", errors, expected_sums.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/mcda_pkg.sv
design/mcda_if.sv
design/mcda_bin2bcd.sv
design/multi_operand_decimal_column_adder.sv
tb/sv/tb_multi_operand_decimal_column_adder.sv
